// ----- rtl/core/world_to_screen_projection_defines.svh -----
// Assertion macros for the world-to-screen projection block.
// Used by the checker module; needs nothing else.
`ifndef WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH
`define WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wts check failed");

// Next-cycle implication, disabled during reset.
`define WTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wts check failed");

`endif

// ----- rtl/core/wts_pkg.sv -----
// Shared constants for the world-to-screen projection block.
// No dependencies.
package wts_pkg;

    localparam int COORD_W          = 32;   // width of every coordinate word
    localparam int CFG_W            = 64;   // config data width
    localparam int NUM_REGS         = 8;
    localparam int REG_IDX_W        = 3;
    localparam int REG_ADDR_LSB     = 3;    // 8-byte register spacing
    localparam int ADDR_W           = REG_IDX_W + REG_ADDR_LSB;
    localparam int DEF_SCREEN_WIDTH  = 1280;
    localparam int DEF_SCREEN_HEIGHT = 720;
    localparam int DEF_FRAC_BITS     = 16;
    localparam int CLIP_W           = 64;   // clip sums, exact
    localparam int MAG_W            = 63;   // magnitude of a clip sum / divisor
    localparam int HALF_BITS        = 13;   // holds SCREEN/2 up to 4096
    // quotient bits kept; 2^QUO_BITS exceeds 2^31 + largest half-screen offset
    localparam int QUO_BITS         = 40;

    localparam logic [CFG_W-1:0] COEF_RESET [NUM_REGS] = '{
        64'd65536, 64'd0, 64'd281474976710656, 64'd0,
        64'd0, 64'd65536, 64'd0, 64'd281474976710656
    };

endpackage

// ----- rtl/core/wts_ifs.sv -----
// Valid/ready channel interfaces for points in and screen results out.
// Depends on wts_pkg.
interface wts_pt_if;
    logic                                valid;
    logic                                ready;
    logic signed [wts_pkg::COORD_W-1:0]  world_x;
    logic signed [wts_pkg::COORD_W-1:0]  world_y;
    logic signed [wts_pkg::COORD_W-1:0]  world_z;

    modport source (output valid, world_x, world_y, world_z, input ready);
    modport sink   (input valid, world_x, world_y, world_z, output ready);
endinterface

interface wts_res_if;
    logic                                valid;
    logic                                ready;
    logic                                visible;
    logic signed [wts_pkg::COORD_W-1:0]  screen_x;
    logic signed [wts_pkg::COORD_W-1:0]  screen_y;

    modport source (output valid, visible, screen_x, screen_y, input ready);
    modport sink   (input valid, visible, screen_x, screen_y, output ready);
endinterface

// ----- rtl/core/world_to_screen_projection.sv -----
// World-to-screen projection: 4x4 matrix transform, perspective divide, viewport map.
// Depends on wts_pkg and the channel interfaces in wts_ifs.sv.
//
//  channel   dir  word                                   handshake
//  i_pt_ch   in   world_x, world_y, world_z (Q.FRAC)     valid/ready
//  o_res_ch  out  visible, screen_x, screen_y (Q.FRAC)   valid/ready
//  APB       in   coef_pair_0..7, 64 bit at 8*i          psel/penable, pready=1
//
// One word per cycle sustained while the output is not stalled;
// the restoring divider resolves one quotient bit per stage.
// Reset (synchronous, active low) clears all stage valids, the skid stage and
// restores the identity matrix.
// A stall on the output parks one word in the skid stage; the pipe then holds
// until the skid drains, so nothing is lost or repeated.
module world_to_screen_projection #(
    parameter int SCREEN_WIDTH  = wts_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = wts_pkg::DEF_SCREEN_HEIGHT,
    parameter int FRAC_BITS     = wts_pkg::DEF_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    wts_pt_if.sink                         i_pt_ch,
    wts_res_if.source                      o_res_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wts_pkg::ADDR_W-1:0]     paddr,
    input  logic [wts_pkg::CFG_W-1:0]      pwdata,
    output logic [wts_pkg::CFG_W-1:0]      prdata,
    output logic                           pready
);

    localparam int CW   = wts_pkg::CLIP_W;
    localparam int MW   = wts_pkg::MAG_W;
    localparam int QB   = wts_pkg::QUO_BITS;
    localparam int HB   = wts_pkg::HALF_BITS;
    localparam int PW   = MW + HB;              // magnitude times half screen
    localparam int NW   = PW + FRAC_BITS;       // dividend width
    localparam int NS   = QB + 6;               // pipeline stages
    localparam int OUT  = NS - 1;
    localparam logic [HB-1:0] HALF_W = HB'(SCREEN_WIDTH / 2);
    localparam logic [HB-1:0] HALF_H = HB'(SCREEN_HEIGHT / 2);
    localparam logic signed [CW-1:0] THRESH =
        CW'(((64'sd1 <<< FRAC_BITS) + 64'sd5) / 64'sd10);
    localparam logic signed [CW-1:0] OFF_X = CW'({51'd0, HALF_W} << FRAC_BITS);
    localparam logic signed [CW-1:0] OFF_Y = CW'({51'd0, HALF_H} << FRAC_BITS);

    typedef struct packed {
        logic          vis;
        logic [MW-1:0] d;
        logic          neg_x;
        logic          neg_y;
        logic          ovf_x;
        logic          ovf_y;
        logic [MW-1:0] rem_x;
        logic [MW-1:0] rem_y;
        logic [QB-1:0] nlo_x;
        logic [QB-1:0] nlo_y;
        logic [QB-1:0] q_x;
        logic [QB-1:0] q_y;
    } t_div;

    typedef struct packed {
        logic                                visible;
        logic signed [wts_pkg::COORD_W-1:0]  screen_x;
        logic signed [wts_pkg::COORD_W-1:0]  screen_y;
    } t_res;

    // one restoring step: returns {quotient bit, new remainder}
    function automatic logic [MW:0] div_step(logic [MW-1:0] rem, logic nbit,
                                             logic [MW-1:0] d);
        logic [MW:0] t;
        logic [MW:0] s;
        t = {rem, nbit};
        s = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            return {1'b1, s[MW-1:0]};
        end
        return {1'b0, t[MW-1:0]};
    endfunction

    function automatic logic signed [wts_pkg::COORD_W-1:0] sat32(logic signed [CW-1:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[wts_pkg::COORD_W-1:0];
    endfunction

    // ---------------- configuration registers ----------------
    logic [wts_pkg::CFG_W-1:0] r_coef [wts_pkg::NUM_REGS];
    logic signed [31:0]        el [16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= wts_pkg::COEF_RESET;
        end else if (psel && penable && pwrite) begin
            r_coef[paddr[wts_pkg::ADDR_W-1:wts_pkg::REG_ADDR_LSB]] <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = r_coef[paddr[wts_pkg::ADDR_W-1:wts_pkg::REG_ADDR_LSB]];

    // matrix element k: even k in low half, odd k in high half
    always_comb begin
        for (int k = 0; k < 16; k++) begin
            el[k] = (k % 2 == 1) ? r_coef[k / 2][63:32] : r_coef[k / 2][31:0];
        end
    end

    // ---------------- pipeline control ----------------
    // Global advance; the skid stage absorbs the one word that leaves the pipe
    // in the cycle the consumer first stalls.
    logic [NS-1:0] r_v;
    logic          r_skid_v;
    t_res          r_skid;
    logic          en;

    assign en = !r_skid_v;
    assign i_pt_ch.ready = en;

    // ---------------- stage 0: products ----------------
    // rows: 0 = clip x, 1 = clip y, 2 = clip w (matrix row 3)
    logic signed [CW-1:0] r_p [3][3];
    // ---------------- stage 1: clip sums ----------------
    logic signed [CW-1:0] r_cx, r_cy, r_cw;
    // ---------------- stage 2: sign/magnitude ----------------
    logic                 r_vis2, r_nx2, r_ny2;
    logic [MW-1:0]        r_ax2, r_ay2, r_d2;
    // ---------------- stage 3: scale by half screen ----------------
    logic                 r_vis3, r_nx3, r_ny3;
    logic [PW-1:0]        r_mx3, r_my3;
    logic [MW-1:0]        r_d3;
    // ---------------- stages 4..4+QB: divider ----------------
    t_div                 r_dv [QB+1];
    t_res                 r_out;

    logic signed [CW-1:0] n_cx, n_cy, n_cw;
    logic signed [CW-1:0] xin, yin, zin;
    logic [NW-1:0]        nx_w, ny_w;
    logic [PW-1:0]        hi_x, hi_y;
    t_div                 n_dv0;
    t_div                 n_dv [QB];
    t_res                 n_out;
    logic [QB:0]          mag_x, mag_y;
    logic signed [CW-1:0] sx, sy;

    assign xin = CW'(i_pt_ch.world_x);
    assign yin = CW'(i_pt_ch.world_y);
    assign zin = CW'(i_pt_ch.world_z);

    // floor shift of each product, then the exact four-term sum
    assign n_cx = (r_p[0][0] >>> FRAC_BITS) + (r_p[0][1] >>> FRAC_BITS)
                + (r_p[0][2] >>> FRAC_BITS) + CW'(el[12]);
    assign n_cy = (r_p[1][0] >>> FRAC_BITS) + (r_p[1][1] >>> FRAC_BITS)
                + (r_p[1][2] >>> FRAC_BITS) + CW'(el[13]);
    assign n_cw = (r_p[2][0] >>> FRAC_BITS) + (r_p[2][1] >>> FRAC_BITS)
                + (r_p[2][2] >>> FRAC_BITS) + CW'(el[15]);

    // divider setup: if the top of the dividend reaches d the quotient
    // overflows QB bits and the result saturates anyway
    always_comb begin
        nx_w = {r_mx3, {FRAC_BITS{1'b0}}};
        ny_w = {r_my3, {FRAC_BITS{1'b0}}};
        hi_x = r_mx3 >> (QB - FRAC_BITS);
        hi_y = r_my3 >> (QB - FRAC_BITS);
        n_dv0.vis   = r_vis3;
        n_dv0.d     = r_d3;
        n_dv0.neg_x = r_nx3;
        n_dv0.neg_y = r_ny3;
        n_dv0.ovf_x = hi_x >= PW'(r_d3);
        n_dv0.ovf_y = hi_y >= PW'(r_d3);
        n_dv0.rem_x = hi_x[MW-1:0];
        n_dv0.rem_y = hi_y[MW-1:0];
        n_dv0.nlo_x = nx_w[QB-1:0];
        n_dv0.nlo_y = ny_w[QB-1:0];
        n_dv0.q_x   = '0;
        n_dv0.q_y   = '0;
    end

    always_comb begin
        logic [MW:0] sxr;
        logic [MW:0] syr;
        for (int k = 0; k < QB; k++) begin
            n_dv[k] = r_dv[k];
            sxr = div_step(r_dv[k].rem_x, r_dv[k].nlo_x[QB-1], r_dv[k].d);
            syr = div_step(r_dv[k].rem_y, r_dv[k].nlo_y[QB-1], r_dv[k].d);
            n_dv[k].rem_x = sxr[MW-1:0];
            n_dv[k].rem_y = syr[MW-1:0];
            n_dv[k].q_x   = {r_dv[k].q_x[QB-2:0], sxr[MW]};
            n_dv[k].q_y   = {r_dv[k].q_y[QB-2:0], syr[MW]};
            n_dv[k].nlo_x = {r_dv[k].nlo_x[QB-2:0], 1'b0};
            n_dv[k].nlo_y = {r_dv[k].nlo_y[QB-2:0], 1'b0};
        end
    end

    // viewport map and saturation
    always_comb begin
        mag_x = r_dv[QB].ovf_x ? ((QB+1)'(1) << QB) : {1'b0, r_dv[QB].q_x};
        mag_y = r_dv[QB].ovf_y ? ((QB+1)'(1) << QB) : {1'b0, r_dv[QB].q_y};
        sx = r_dv[QB].neg_x ? OFF_X - CW'(mag_x) : OFF_X + CW'(mag_x);
        sy = r_dv[QB].neg_y ? OFF_Y + CW'(mag_y) : OFF_Y - CW'(mag_y);
        n_out.visible  = r_dv[QB].vis;
        n_out.screen_x = r_dv[QB].vis ? sat32(sx) : '0;
        n_out.screen_y = r_dv[QB].vis ? sat32(sy) : '0;
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p[0][0] <= xin * CW'(el[0]);
            r_p[0][1] <= yin * CW'(el[4]);
            r_p[0][2] <= zin * CW'(el[8]);
            r_p[1][0] <= xin * CW'(el[1]);
            r_p[1][1] <= yin * CW'(el[5]);
            r_p[1][2] <= zin * CW'(el[9]);
            r_p[2][0] <= xin * CW'(el[3]);
            r_p[2][1] <= yin * CW'(el[7]);
            r_p[2][2] <= zin * CW'(el[11]);

            r_cx <= n_cx;
            r_cy <= n_cy;
            r_cw <= n_cw;

            r_vis2 <= r_cw >= THRESH;
            r_nx2  <= r_cx[CW-1];
            r_ny2  <= r_cy[CW-1];
            r_ax2  <= r_cx[CW-1] ? MW'(-r_cx) : MW'(r_cx);
            r_ay2  <= r_cy[CW-1] ? MW'(-r_cy) : MW'(r_cy);
            r_d2   <= MW'(r_cw);

            r_vis3 <= r_vis2;
            r_nx3  <= r_nx2;
            r_ny3  <= r_ny2;
            r_d3   <= r_d2;
            r_mx3  <= PW'(r_ax2) * PW'(HALF_W);
            r_my3  <= PW'(r_ay2) * PW'(HALF_H);

            r_dv[0] <= n_dv0;
            for (int k = 0; k < QB; k++) begin
                r_dv[k+1] <= n_dv[k];
            end
            r_out <= n_out;
        end
        if (!r_skid_v && r_v[OUT] && !o_res_ch.ready) begin
            r_skid <= r_out;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v      <= '0;
            r_skid_v <= 1'b0;
        end else begin
            if (en) begin
                r_v <= {r_v[NS-2:0], i_pt_ch.valid};
            end
            if (r_skid_v) begin
                if (o_res_ch.ready) begin
                    r_skid_v <= 1'b0;
                end
            end else if (r_v[OUT] && !o_res_ch.ready) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    assign o_res_ch.valid    = r_skid_v || r_v[OUT];
    assign o_res_ch.visible  = r_skid_v ? r_skid.visible  : r_out.visible;
    assign o_res_ch.screen_x = r_skid_v ? r_skid.screen_x : r_out.screen_x;
    assign o_res_ch.screen_y = r_skid_v ? r_skid.screen_y : r_out.screen_y;

endmodule

// ----- rtl/core/wts_chk.sv -----
// Port-level checker for world_to_screen_projection, with its bind.
// Depends on wts_pkg and world_to_screen_projection_defines.svh.
`include "world_to_screen_projection_defines.svh"

module wts_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic                                i_visible,
    input logic signed [wts_pkg::COORD_W-1:0]  i_screen_x,
    input logic signed [wts_pkg::COORD_W-1:0]  i_screen_y,
    input logic                                i_pready
);

    // hidden points carry zero coordinates
    `WTS_ASSERT_NOW(a_hidden_zero, i_clk, i_rst_n, i_out_valid && !i_visible, i_screen_x == '0 && i_screen_y == '0)

    // APB never waits
    `WTS_ASSERT_NOW(a_pready, i_clk, i_rst_n, 1'b1, i_pready)

    // a stalled word holds
    `WTS_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_visible) && $stable(i_screen_x) && $stable(i_screen_y))

endmodule

bind world_to_screen_projection wts_chk u_wts_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res_ch.valid),
    .i_out_ready (o_res_ch.ready),
    .i_visible   (o_res_ch.visible),
    .i_screen_x  (o_res_ch.screen_x),
    .i_screen_y  (o_res_ch.screen_y),
    .i_pready    (pready)
);
